>>> rtl/ttw_pkg.sv
// shared types and constants for the text terminal writer
package ttw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 2;

  // cell values
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_ATTR, BLANK_CHAR};
  localparam logic [COL_W:0]    TAB_MASK     = 8'h07;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  // sequencer states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCROLL,
    ST_DONE
  } state_t;

  // screen memory write request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  // screen memory read request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

>>> rtl/ttw_in_if.sv
// request channel into the terminal writer
interface ttw_in_if
  import ttw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_index;

  modport source (output valid, cmd, char_code, cell_index, input ready);
  modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

>>> rtl/ttw_out_if.sv
// result channel out of the terminal writer
interface ttw_out_if
  import ttw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_word;
  logic [ADDR_W-1:0] cursor_pos;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  modport source (output valid, cell_word, cursor_pos, cursor_col, cursor_row, input ready);
  modport sink   (input valid, cell_word, cursor_pos, cursor_col, cursor_row, output ready);
endinterface

>>> rtl/text_terminal_writer.sv
// top level of the text terminal writer: sequencer, cursor and result register
//
// Usage: requests arrive on in_ch (cmd, char_code, cell_index) with a
// valid/ready handshake; each request gives exactly one result on out_ch
// (cell_word, cursor_pos, cursor_col, cursor_row). cfg_we/cfg_wdata write the
// attribute byte used for written and blanked cells; write it only while idle.
// The screen is an 80x25 array of 16-bit cells kept in one memory with a
// registered read; the cursor lives in flops.
// Sequencing: a put without scroll, a read or an unused command goes from
// request to result register by accept, then completion. A put that
// scrolls copies 1920 cells at one per cycle and blanks the last row.
// Clear writes all 2000 cells one per cycle.
// The rate is set by the single write port of the screen memory.
// Reset: the cursor homes, the attribute becomes 0x07 and a clearing pass
// writes 0x0720 into every cell; in_ch.ready stays low meanwhile.
// Stall: the result register holds while out_ch.ready is low; the next
// request is still taken, and its result waits until the register frees.
module text_terminal_writer
  import ttw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ttw_in_if.sink           in_ch,
  ttw_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              init_r;
  logic [CELL_W-1:0] blank_r;
  logic [CHAR_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              word_sel_r;
  logic              cp_valid_r;
  logic [ADDR_W-1:0] cp_addr_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_word_r;
  logic [ADDR_W-1:0] out_pos_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;

  logic              accept;
  logic              out_free;
  logic              idx_ok;
  ram_wr_t           ram_wr, put_wr;
  ram_rd_t           ram_rd;
  logic [CELL_W-1:0] ram_rdata;

  logic [ADDR_W-1:0] here;
  logic [COL_W:0]    put_col;
  logic [ROW_W:0]    put_row;
  logic [COL_W-1:0]  put_col_fin;
  logic [ROW_W-1:0]  put_row_fin;
  logic              put_scroll;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_ok   = in_ch.cell_index < ADDR_W'(CELL_COUNT);

  // put decode: cursor move and cell write
  always_comb begin
    here = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
    put_col = {1'b0, col_r};
    put_row = {1'b0, row_r};
    put_wr  = '0;
    case (in_ch.char_code)
      CH_LF: begin
        put_col = '0;
        put_row = put_row + 1'b1;
      end
      CH_CR: begin
        put_col = '0;
      end
      CH_BS: begin
        if (col_r != '0) begin
          put_col = put_col - 1'b1;
          put_wr  = '{en: 1'b1, addr: here - 1'b1, data: {attr_r, BLANK_CHAR}};
        end
      end
      CH_TAB: begin
        put_col = (put_col + (COL_W+1)'(8)) & ~TAB_MASK;
      end
      default: begin
        put_wr  = '{en: 1'b1, addr: here, data: {attr_r, in_ch.char_code}};
        put_col = put_col + 1'b1;
      end
    endcase
    if (put_col >= (COL_W+1)'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    put_scroll  = put_row >= (ROW_W+1)'(ROWS);
    put_col_fin = put_col[COL_W-1:0];
    put_row_fin = put_scroll ? ROW_W'(ROWS - 1) : put_row[ROW_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (!cp_valid_r && cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = init_r ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            CMD_PUT:   state_nxt = put_scroll ? ST_SCROLL : ST_DONE;
            CMD_CLEAR: state_nxt = ST_FILL;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCROLL: begin
        if (cnt_r == ADDR_W'(CELL_COUNT - COLUMNS - 1)) begin
          state_nxt = ST_FILL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake, memory ports, sweep counter
  always_comb begin
    in_ch.ready = 1'b0;
    ram_rd      = '0;
    ram_wr      = '0;
    cnt_nxt     = cnt_r;
    unique case (state_r)
      ST_FILL: begin
        if (!cp_valid_r) begin
          ram_wr  = '{en: 1'b1, addr: cnt_r, data: blank_r};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        cnt_nxt     = '0;
        if (accept && in_ch.cmd == CMD_PUT) begin
          ram_wr = put_wr;
        end
        if (accept && in_ch.cmd == CMD_READ && idx_ok) begin
          ram_rd = '{en: 1'b1, addr: in_ch.cell_index};
        end
      end
      ST_SCROLL: begin
        ram_rd  = '{en: 1'b1, addr: cnt_r + ADDR_W'(COLUMNS)};
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_DONE: begin
        cnt_nxt = cnt_r;
      end
      default: cnt_nxt = cnt_r;
    endcase
    // pending copy owns the write port
    if (cp_valid_r) begin
      ram_wr = '{en: 1'b1, addr: cp_addr_r, data: ram_rdata};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      cnt_r      <= '0;
      init_r     <= 1'b1;
      blank_r    <= RESET_BLANK;
      attr_r     <= RESET_ATTR;
      col_r      <= '0;
      row_r      <= '0;
      word_sel_r <= 1'b0;
      cp_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      cp_valid_r <= state_r == ST_SCROLL;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (accept) begin
        init_r     <= 1'b0;
        blank_r    <= {attr_r, BLANK_CHAR};
        word_sel_r <= in_ch.cmd == CMD_READ && idx_ok;
        case (in_ch.cmd)
          CMD_PUT: begin
            col_r <= put_col_fin;
            row_r <= put_row_fin;
          end
          CMD_CLEAR: begin
            col_r <= '0;
            row_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // copy write address follows the read in the next cycle
  always_ff @(posedge clk) begin
    cp_addr_r <= cnt_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_word_r <= word_sel_r ? ram_rdata : '0;
      out_pos_r  <= ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
      out_col_r  <= col_r;
      out_row_r  <= row_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_word  = out_word_r;
  assign out_ch.cursor_pos = out_pos_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;

  // screen memory
  ttw_screen_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rdata)
  );

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < COL_W'(COLUMNS) && row_r < ROW_W'(ROWS))
    else $error("cursor off screen");

  // a pending copy only follows a scroll read
  a_copy_origin: assert property (@(posedge clk) disable iff (!rst_n)
    cp_valid_r |-> $past(state_r) == ST_SCROLL)
    else $error("copy write without scroll read");

  // scroll reads stay inside the screen
  a_scroll_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCROLL |-> cnt_r < ADDR_W'(CELL_COUNT - COLUMNS))
    else $error("scroll read beyond screen");

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("second request taken before completion");

endmodule

>>> rtl/ttw_screen_ram.sv
// screen cell memory, one write port and one registered read port
module ttw_screen_ram
  import ttw_pkg::*;
(
  input  logic              clk,
  input  ram_wr_t           wr,
  input  ram_rd_t           rd,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
